FILE: hdl/eli_pkg.sv
// shared constants and types for the ephemeris linear interpolator
package eli_pkg;
   localparam int TimeWidth = 54;
   localparam int RaWidth = 31;
   localparam int DecWidth = 30;
   localparam int DefaultDepth = 1024;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;

   localparam logic [2:0] ST_INTERP = 3'd0;
   localparam logic [2:0] ST_FIRST = 3'd1;
   localparam logic [2:0] ST_LAST = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_ACCEPT = 3'd4;
   localparam logic [2:0] ST_FULL = 3'd5;
   localparam logic [2:0] ST_ORDER = 3'd6;

   localparam logic [RaWidth-1:0] RA_FULL = 31'd1509949440;
   localparam logic signed [32:0] RA_HALF_S = 33'sd754974720;
   localparam logic signed [32:0] RA_FULL_S = 33'sd1509949440;
   localparam logic signed [DecWidth-1:0] DEC_LIMIT = 30'sd377487360;

   typedef logic [TimeWidth-1:0] time_type;
endpackage

FILE: hdl/ephemeris_linear_interpolator.sv
// top level: point table in memories, binary search, serial ratio divide, interpolation
//
// Point table of up to TABLE_DEPTH (time, ra, dec) entries held in three synchronous
// memories. One request is worked at a time. The result register holds the answer until
// it is taken, and ready returns the cycle after the result leaves. Clear and an
// empty-table query go straight to the output. Append reads the last point to check the
// order, but an append into an empty table skips that read. A query runs up to
// s = ceil(log2(count+1)) search steps (address, then compare on the registered read),
// plus one closing step. A clamp then reads the end point and wraps. An interpolation
// reads the bracketing points, runs the 33 steps of the serial restoring divider for
// the ratio, then does scale, sum and wrap in turn. A stalled result holds the block
// for as long as rsp_ready stays low.
module ephemeris_linear_interpolator #(
   parameter int TABLE_DEPTH = eli_pkg::DefaultDepth
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_op,
   input  logic [eli_pkg::TimeWidth-1:0] req_time_days,
   input  logic [eli_pkg::RaWidth-1:0] req_ra_in,
   input  logic signed [eli_pkg::DecWidth-1:0] req_dec_in,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [eli_pkg::TimeWidth-1:0] rsp_time_out,
   output logic [eli_pkg::RaWidth-1:0] rsp_ra_out,
   output logic signed [eli_pkg::DecWidth-1:0] rsp_dec_out
);
   import eli_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_APRD = 4'd1;
   localparam logic [3:0] S_APCK = 4'd2;
   localparam logic [3:0] S_SRCH = 4'd3;
   localparam logic [3:0] S_SRWT = 4'd4;
   localparam logic [3:0] S_RDUP = 4'd5;
   localparam logic [3:0] S_RDDN = 4'd6;
   localparam logic [3:0] S_CAPT = 4'd7;
   localparam logic [3:0] S_DIV = 4'd8;
   localparam logic [3:0] S_MUL = 4'd9;
   localparam logic [3:0] S_SUM = 4'd10;
   localparam logic [3:0] S_WRAP = 4'd11;
   localparam logic [3:0] S_OUT = 4'd12;
   localparam logic [3:0] S_CLMP = 4'd13;

   logic [TimeWidth-1:0] mem_time [TABLE_DEPTH];
   logic [RaWidth-1:0] mem_ra [TABLE_DEPTH];
   logic signed [DecWidth-1:0] mem_dec [TABLE_DEPTH];

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0] rd_addr;
   logic [TimeWidth-1:0] rd_time_ff;
   logic [RaWidth-1:0] rd_ra_ff;
   logic signed [DecWidth-1:0] rd_dec_ff;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [TimeWidth-1:0] qt_ff;
   logic [RaWidth-1:0] ra_ff;
   logic signed [DecWidth-1:0] dec_ff;
   // upper point captured, then used for differences
   logic [TimeWidth-1:0] tup_ff;
   logic [RaWidth-1:0] raup_ff;
   logic signed [DecWidth-1:0] decup_ff;
   logic [TimeWidth:0] rem_ff, den_ff;
   logic [32:0] quo_ff;
   logic [5:0] cnt_ff;
   logic signed [32:0] rd_diff_ff, dd_diff_ff;
   logic signed [32:0] rd_dlt_ff, dd_dlt_ff;
   logic signed [32:0] ra_sum_ff;
   logic signed [DecWidth:0] dec_sum_ff;
   logic out_valid_ff;
   logic [2:0] st_ff;
   logic [TimeWidth-1:0] to_ff;
   logic [RaWidth-1:0] ro_ff;
   logic signed [DecWidth-1:0] do_ff;

   logic [CW-1:0] mid;
   logic [RaWidth-1:0] ra_norm;
   logic signed [DecWidth-1:0] dec_sat;
   logic [TimeWidth:0] rem_sh;
   logic [65:0] rd_prod, dd_prod;
   logic [32:0] rd_mag, dd_mag;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign req_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign wr_en = (state_ff == S_APCK) && (count_ff < CW'(TABLE_DEPTH))
      && ((count_ff == '0) || (qt_ff > rd_time_ff));
   assign wr_addr = count_ff[AW-1:0];
   assign ra_norm = (ra_ff >= RA_FULL) ? ra_ff - RA_FULL : ra_ff;
   assign dec_sat = (dec_ff > DEC_LIMIT) ? DEC_LIMIT :
      (dec_ff < -DEC_LIMIT) ? -DEC_LIMIT : dec_ff;
   assign rem_sh = {rem_ff[TimeWidth-1:0], 1'b0};
   assign rd_mag = rd_diff_ff[32] ? 33'(-rd_diff_ff) : 33'(rd_diff_ff);
   assign dd_mag = dd_diff_ff[32] ? 33'(-dd_diff_ff) : 33'(dd_diff_ff);
   assign rd_prod = rd_mag * quo_ff;
   assign dd_prod = dd_mag * quo_ff;

   always_comb begin
      case (state_ff)
         S_APRD: rd_addr = AW'(count_ff - 1'b1);
         S_SRCH: rd_addr = mid[AW-1:0];
         S_RDUP: rd_addr = lo_ff[AW-1:0];
         S_RDDN: rd_addr = AW'(lo_ff - 1'b1);
         S_CLMP: rd_addr = (lo_ff == '0) ? '0 : AW'(count_ff - 1'b1);
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_time[wr_addr] <= qt_ff;
         mem_ra[wr_addr] <= ra_norm;
         mem_dec[wr_addr] <= dec_sat;
      end
      rd_time_ff <= mem_time[rd_addr];
      rd_ra_ff <= mem_ra[rd_addr];
      rd_dec_ff <= mem_dec[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_op == OP_CLEAR) begin
                  count_in = '0;
                  state_in = S_OUT;
               end else if (req_op == OP_APPEND) begin
                  state_in = (count_ff == '0) ? S_APCK : S_APRD;
               end else begin
                  lo_in = '0;
                  hi_in = count_ff;
                  state_in = (count_ff == '0) ? S_OUT : S_SRCH;
               end
            end
         end
         S_APRD: state_in = S_APCK;
         S_APCK: begin
            if (wr_en) count_in = count_ff + 1'b1;
            state_in = S_OUT;
         end
         S_SRCH: state_in = (lo_ff < hi_ff) ? S_SRWT : S_RDUP;
         S_SRWT: begin
            if (rd_time_ff < qt_ff) lo_in = mid + 1'b1;
            else hi_in = mid;
            state_in = S_SRCH;
         end
         S_RDUP: begin
            if (lo_ff == '0 || lo_ff >= count_ff) state_in = S_CLMP;
            else state_in = S_RDDN;
         end
         S_RDDN: state_in = S_CAPT;
         S_CAPT: state_in = S_DIV;
         S_DIV: if (cnt_ff == 6'd32) state_in = S_MUL;
         S_MUL: state_in = S_SUM;
         S_SUM: state_in = S_WRAP;
         S_WRAP: state_in = S_OUT;
         S_CLMP: state_in = S_WRAP;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         if (state_ff == S_OUT) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            // load only on an accepted request so a pending result stays put
            if (req_valid && req_ready) begin
               qt_ff <= req_time_days;
               ra_ff <= req_ra_in;
               dec_ff <= req_dec_in;
               st_ff <= ST_ACCEPT;
               to_ff <= '0;
               ro_ff <= '0;
               do_ff <= '0;
               if (req_op != OP_CLEAR && req_op != OP_APPEND) begin
                  st_ff <= ST_EMPTY;
                  to_ff <= req_time_days;
               end
            end
         end
         S_APCK: begin
            if (count_ff >= CW'(TABLE_DEPTH)) st_ff <= ST_FULL;
            else if (!wr_en) st_ff <= ST_ORDER;
            else begin
               st_ff <= ST_ACCEPT;
               to_ff <= qt_ff;
               ro_ff <= ra_norm;
               do_ff <= dec_sat;
            end
         end
         S_RDDN: begin
            tup_ff <= rd_time_ff;
            raup_ff <= rd_ra_ff;
            decup_ff <= rd_dec_ff;
         end
         S_CAPT: begin
            rem_ff <= {1'b0, qt_ff - rd_time_ff};
            den_ff <= {1'b0, tup_ff - rd_time_ff};
            quo_ff <= '0;
            cnt_ff <= '0;
            rd_diff_ff <= $signed({2'b00, raup_ff}) - $signed({2'b00, rd_ra_ff});
            dd_diff_ff <= 33'(decup_ff) - 33'(rd_dec_ff);
            ra_ff <= rd_ra_ff;
            dec_ff <= rd_dec_ff;
         end
         S_DIV: begin
            // first step compares unshifted, then 32 shift-subtract steps
            if (cnt_ff == '0) begin
               if (rem_ff >= den_ff) begin
                  rem_ff <= rem_ff - den_ff;
                  quo_ff <= 33'd1;
               end
            end else if (rem_sh >= den_ff) begin
               rem_ff <= rem_sh - den_ff;
               quo_ff <= {quo_ff[31:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[31:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (rd_diff_ff > RA_HALF_S) rd_diff_ff <= rd_diff_ff - RA_FULL_S;
            else if (rd_diff_ff < -RA_HALF_S) rd_diff_ff <= rd_diff_ff + RA_FULL_S;
         end
         S_MUL: begin
            rd_dlt_ff <= rd_diff_ff[32] ? -$signed({1'b0, rd_prod[63:32]})
               : $signed({1'b0, rd_prod[63:32]});
            dd_dlt_ff <= dd_diff_ff[32] ? -$signed({1'b0, dd_prod[63:32]})
               : $signed({1'b0, dd_prod[63:32]});
         end
         S_SUM: begin
            ra_sum_ff <= $signed({2'b00, ra_ff}) + rd_dlt_ff;
            dec_sum_ff <= (DecWidth+1)'(33'(dec_ff) + dd_dlt_ff);
         end
         S_CLMP: begin
            st_ff <= (lo_ff == '0) ? ST_FIRST : ST_LAST;
         end
         S_WRAP: begin
            if (st_ff == ST_EMPTY) begin
               st_ff <= ST_INTERP;
               to_ff <= qt_ff;
               if (ra_sum_ff < 0) ro_ff <= RaWidth'(ra_sum_ff + RA_FULL_S);
               else if (ra_sum_ff >= RA_FULL_S) ro_ff <= RaWidth'(ra_sum_ff - RA_FULL_S);
               else ro_ff <= RaWidth'(ra_sum_ff);
               do_ff <= DecWidth'(dec_sum_ff);
            end else begin
               to_ff <= rd_time_ff;
               ro_ff <= rd_ra_ff;
               do_ff <= rd_dec_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = st_ff;
   assign rsp_time_out = to_ff;
   assign rsp_ra_out = ro_ff;
   assign rsp_dec_out = do_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH)) else $error("point count past depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !req_ready) else $error("ready while result pending");
   a_write_in_append: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + 1'b1) else $error("write without count step");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH |-> lo_ff <= hi_ff) else $error("search bounds crossed");
`endif
endmodule

FILE: tb/sv/ephemeris_linear_interpolator_tb.sv
// self-checking testbench for the ephemeris linear interpolator
module ephemeris_linear_interpolator_tb;
   import eli_pkg::*;

   localparam int Depth = DefaultDepth;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam logic [TimeWidth-1:0] TIME_MAX = {TimeWidth{1'b1}};
   localparam longint RaFull = 64'd1509949440;
   localparam longint RaHalf = 64'd754974720;
   localparam longint DecLimit = 64'd377487360;
   localparam int TailCycles = 120;
   localparam int LongTable = 100;
   localparam int PhaseRequests = 170;

   typedef struct packed {
      logic [2:0] status;
      logic [TimeWidth-1:0] time_out;
      logic [RaWidth-1:0] ra;
      logic signed [DecWidth-1:0] dec;
   } point_result_type;

   class eph_scoreboard_type;
      logic [TimeWidth-1:0] tbl_time[Depth];
      logic [RaWidth-1:0] tbl_ra[Depth];
      logic signed [DecWidth-1:0] tbl_dec[Depth];
      int count;
      point_result_type expected[$];
      int errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      // restoring divide: (num << 32) / den with num <= den
      function longint unsigned ratio(longint unsigned num, longint unsigned den);
         longint unsigned q;
         longint unsigned r;
         q = 0;
         r = num;
         if (r >= den) begin
            r -= den;
            q = 1;
         end
         for (int i = 0; i < 32; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r -= den;
               q |= 1;
            end
         end
         return q;
      endfunction

      // d * t / 2^32, truncated toward zero
      function longint scaled(longint d, longint unsigned t);
         longint unsigned mag;
         longint unsigned p;
         mag = (d < 0) ? longint'(-d) : longint'(d);
         p = (mag * t) >> 32;
         return (d < 0) ? -longint'(p) : longint'(p);
      endfunction

      function void note_request(logic [1:0] op, logic [TimeWidth-1:0] tm,
                                 logic [RaWidth-1:0] ra_in, logic signed [DecWidth-1:0] dec_in);
         point_result_type r;
         longint sra;
         longint sdec;
         int lo;
         int hi;
         int mid;
         longint unsigned t;
         r = '0;
         if (op == OP_CLEAR) begin
            count = 0;
            r.status = ST_ACCEPT;
         end else if (op == OP_APPEND) begin
            sra = longint'(ra_in);
            sdec = longint'(dec_in);
            if (count >= Depth) begin
               r.status = ST_FULL;
            end else if (count > 0 && tm <= tbl_time[count-1]) begin
               r.status = ST_ORDER;
            end else begin
               if (sra >= RaFull) sra -= RaFull;
               if (sdec > DecLimit) sdec = DecLimit;
               if (sdec < -DecLimit) sdec = -DecLimit;
               tbl_time[count] = tm;
               tbl_ra[count] = RaWidth'(sra);
               tbl_dec[count] = DecWidth'(sdec);
               count++;
               r = '{ST_ACCEPT, tm, RaWidth'(sra), DecWidth'(sdec)};
            end
         end else if (count == 0) begin
            r.status = ST_EMPTY;
            r.time_out = tm;
         end else begin
            lo = 0;
            hi = count;
            while (lo < hi) begin
               mid = lo + (hi - lo) / 2;
               if (tbl_time[mid] < tm) lo = mid + 1;
               else hi = mid;
            end
            if (lo == 0) begin
               r = '{ST_FIRST, tbl_time[0], tbl_ra[0], tbl_dec[0]};
            end else if (lo >= count) begin
               r = '{ST_LAST, tbl_time[count-1], tbl_ra[count-1], tbl_dec[count-1]};
            end else begin
               t = ratio(tm - tbl_time[lo-1], tbl_time[lo] - tbl_time[lo-1]);
               sra = longint'(tbl_ra[lo]) - longint'(tbl_ra[lo-1]);
               if (sra > RaHalf) sra -= RaFull;
               else if (sra < -RaHalf) sra += RaFull;
               sra = longint'(tbl_ra[lo-1]) + scaled(sra, t);
               if (sra < 0) sra += RaFull;
               if (sra >= RaFull) sra -= RaFull;
               sdec = longint'(tbl_dec[lo]) - longint'(tbl_dec[lo-1]);
               sdec = longint'(tbl_dec[lo-1]) + scaled(sdec, t);
               r = '{ST_INTERP, tm, RaWidth'(sra), DecWidth'(sdec)};
            end
         end
         expected.insert(expected.size(), r);
      endfunction

      function void check_result(point_result_type got);
         point_result_type exp_r;
         if (expected.size() == 0) begin
            $display("%0t: unexpected result status %0d time %0d ra %0d dec %0d", $time,
                     got.status, got.time_out, got.ra, got.dec);
            errors++;
            return;
         end
         exp_r = expected.pop_front();
         if (got.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
            errors++;
         end
         if (got.time_out !== exp_r.time_out) begin
            $display("%0t: time_out expected %0d actual %0d", $time, exp_r.time_out,
                     got.time_out);
            errors++;
         end
         if (got.ra !== exp_r.ra) begin
            $display("%0t: ra_out expected %0d actual %0d", $time, exp_r.ra, got.ra);
            errors++;
         end
         if (got.dec !== exp_r.dec) begin
            $display("%0t: dec_out expected %0d actual %0d", $time, exp_r.dec, got.dec);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_op;
   logic [TimeWidth-1:0] req_time_days;
   logic [RaWidth-1:0] req_ra_in;
   logic signed [DecWidth-1:0] req_dec_in;
   logic rsp_valid;
   logic rsp_ready;
   logic [2:0] rsp_status;
   logic [TimeWidth-1:0] rsp_time_out;
   logic [RaWidth-1:0] rsp_ra_out;
   logic signed [DecWidth-1:0] rsp_dec_out;

   eph_scoreboard_type sb = new();
   int send_idle;
   int recv_idle;
   int requests;
   logic [TimeWidth-1:0] seq_time[64];

   ephemeris_linear_interpolator u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_time_days(req_time_days),
      .req_ra_in(req_ra_in),
      .req_dec_in(req_dec_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_time_out(rsp_time_out),
      .rsp_ra_out(rsp_ra_out),
      .rsp_dec_out(rsp_dec_out)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result('{rsp_status, rsp_time_out, rsp_ra_out, rsp_dec_out});
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic logic [TimeWidth-1:0] rand_time();
      return {$urandom, $urandom} & TIME_MAX;
   endfunction

   // one request, held until accepted
   task automatic send(logic [1:0] op, logic [TimeWidth-1:0] tm,
                       logic [RaWidth-1:0] ra, logic signed [DecWidth-1:0] dec);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_time_days <= tm;
      req_ra_in <= ra;
      req_dec_in <= dec;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, tm, ra, dec);
      requests++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   task automatic rand_point(logic [TimeWidth-1:0] tm);
      logic [RaWidth-1:0] ra;
      logic signed [DecWidth-1:0] dec;
      ra = ($urandom_range(3) == 0) ? RaWidth'($urandom) : RaWidth'($urandom_range(1509949439));
      dec = ($urandom_range(3) == 0) ? DecWidth'($urandom)
            : DecWidth'($urandom_range(754974720) - 377487360);
      send(OP_APPEND, tm, ra, dec);
   endtask

   // clear, ascending points, then queries mostly inside the span
   task automatic run_sequence();
      int n;
      int k;
      int sh;
      logic [TimeWidth-1:0] tm;
      logic [TimeWidth-1:0] span;
      n = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      sh = $urandom_range(1, 40);
      seq_time[0] = rand_time() >> 1;
      send(OP_CLEAR, rand_time(), RaWidth'($urandom), DecWidth'($urandom));
      for (int i = 0; i < n; i++) begin
         if (i > 0)
            seq_time[i] = seq_time[i-1] + 1 + (rand_time() & ((54'd1 << sh) - 1));
         rand_point(seq_time[i]);
         if ($urandom_range(15) == 0)
            rand_point(seq_time[i] - $urandom_range(1));
      end
      for (int j = $urandom_range(2, 8); j > 0; j--) begin
         k = $urandom_range(n - 1);
         case ($urandom_range(5))
            0: tm = seq_time[0] - $urandom_range(1);
            1: tm = seq_time[n-1] + $urandom_range(1);
            2: tm = seq_time[k];
            default: begin
               if (k == n - 1) tm = seq_time[k];
               else begin
                  span = seq_time[k+1] - seq_time[k];
                  tm = seq_time[k] + ({$urandom, $urandom} % (span + 1));
               end
            end
         endcase
         send(($urandom_range(7) == 0) ? OP_SPARE : OP_QUERY, tm, RaWidth'($urandom),
              DecWidth'($urandom));
      end
   endtask

   initial begin
      int phase_end;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_CLEAR;
      req_time_days = '0;
      req_ra_in = '0;
      req_dec_in = '0;
      send_idle = 28;
      recv_idle = 81;
      requests = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty, saturation, ordering, wrap, clamps, exact ends
      send(OP_CLEAR, TIME_MAX, 31'h7fffffff, 30'sh1fffffff);
      send(OP_QUERY, 54'd5, '0, '0);
      send(OP_APPEND, 54'd1000, 31'h7fffffff, 30'sh1fffffff);
      send(OP_APPEND, 54'd1000, 31'd5, 30'sd5);
      send(OP_APPEND, 54'd500, 31'd5, 30'sd5);
      send(OP_APPEND, 54'd2000, 31'd10, -30'sh20000000);
      send(OP_APPEND, 54'd3000, RA_FULL - 31'd5, 30'sd1000);
      send(OP_APPEND, TIME_MAX, 31'd754974720, 30'sd0);
      send(OP_QUERY, 54'd0, '0, '0);
      send(OP_QUERY, 54'd1000, '0, '0);
      send(OP_QUERY, 54'd1500, '0, '0);
      send(OP_QUERY, 54'd2000, '0, '0);
      send(OP_QUERY, 54'd2500, '0, '0);
      send(OP_QUERY, 54'd2999, '0, '0);
      send(OP_SPARE, TIME_MAX - 54'd1, '0, '0);
      send(OP_QUERY, TIME_MAX, '0, '0);
      send(OP_CLEAR, '0, '0, '0);
      send(OP_APPEND, 54'd50, RA_FULL, 30'sd7);
      send(OP_QUERY, 54'd60, '0, '0);
      send(OP_QUERY, 54'd50, '0, '0);
      send(OP_SPARE, 54'd10, '0, '0);
      drain();

      // long table, deep searches
      send(OP_CLEAR, '0, '0, '0);
      for (int i = 0; i < LongTable; i++)
         rand_point((54'(i) + 1) << 40);
      rand_point(TIME_MAX);
      for (int i = 0; i < 12; i++)
         send(OP_QUERY, rand_time() & ((54'd1 << 47) - 1), '0, '0);
      drain();

      phase_end = requests + PhaseRequests;
      while (requests < phase_end) begin
         if ($urandom_range(4) == 0)
            send(2'($urandom), rand_time(), RaWidth'($urandom), DecWidth'($urandom));
         else
            run_sequence();
      end
      drain();
      send_idle = 81;
      recv_idle = 28;
      phase_end = requests + PhaseRequests;
      while (requests < phase_end) begin
         if ($urandom_range(4) == 0)
            send(2'($urandom), rand_time(), RaWidth'($urandom), DecWidth'($urandom));
         else
            run_sequence();
      end
      drain();
      send_idle = 0;
      recv_idle = 0;
      phase_end = requests + PhaseRequests;
      while (requests < phase_end) begin
         if ($urandom_range(4) == 0)
            send(2'($urandom), rand_time(), RaWidth'($urandom), DecWidth'($urandom));
         else
            run_sequence();
      end
      drain();

      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #80000000;
      $display("Mismatches found");
      $finish;
   end
endmodule
